FILE: hdl/fdr_pkg.sv
// Shared types and constants for the Fresnel dielectric reflectance block.
`timescale 1ns / 1ps
package fdr_pkg;
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_ETA_INCIDENT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ETA_TRANSMIT = 2'd1;

  localparam logic [16:0] ONE_Q16 = 17'h10000;
  localparam logic signed [15:0] COS_POS_ONE = 16'sd16384;
  localparam logic signed [15:0] COS_NEG_ONE = -16'sd16384;

  // word handed from the front end to the back end through the queue
  typedef struct packed {
    logic        tir;   // total internal reflection
    logic [63:0] num;   // (et^2*2^28 - ei^2*sin^2) << 4
    logic [31:0] den;   // et^2
    logic [14:0] ac;    // |cos|, Q1.14
    logic [15:0] ei;
    logic [15:0] et;
  } fdr_item_t;
endpackage

FILE: hdl/fdr_front.sv
// Front end: clamp, swap indices, sine term and exact total internal reflection test.
`timescale 1ns / 1ps
module fdr_front import fdr_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_cos_incidence,
  input  logic [15:0]        eta_i,
  input  logic [15:0]        eta_t,
  input  logic               q_full,
  output logic               q_push,
  output fdr_item_t          q_item
);
  logic fe;
  logic signed [15:0] c_clamp, c_abs;
  logic exiting;

  logic v1_r, v2_r, v3_r, v4_r;
  logic [14:0] ac1_r, ac2_r, ac3_r, ac4_r;
  logic [15:0] ei1_r, ei2_r, ei3_r, ei4_r;
  logic [15:0] et1_r, et2_r, et3_r, et4_r;
  logic [29:0] acsq2_r;
  logic [31:0] eisq2_r, eisq3_r;
  logic [31:0] etsq2_r, etsq3_r, etsq4_r;
  logic [28:0] sin2_3_r;
  logic [60:0] lhs4_r;

  logic [29:0] acsq_nxt;
  logic [31:0] eisq_nxt, etsq_nxt;
  logic [28:0] sin2_nxt;
  logic [60:0] lhs_nxt, rhs, diff;

  assign fe       = !(v4_r && q_full);
  assign in_stall = !fe;
  assign q_push   = v4_r && fe;

  always_comb begin
    c_clamp = in_cos_incidence;
    if (in_cos_incidence > COS_POS_ONE) begin
      c_clamp = COS_POS_ONE;
    end else if (in_cos_incidence < COS_NEG_ONE) begin
      c_clamp = COS_NEG_ONE;
    end
    exiting = (c_clamp <= 16'sd0);
    c_abs   = exiting ? -c_clamp : c_clamp;
  end

  assign acsq_nxt = 30'(ac1_r) * 30'(ac1_r);
  assign eisq_nxt = 32'(ei1_r) * 32'(ei1_r);
  assign etsq_nxt = 32'(et1_r) * 32'(et1_r);
  assign sin2_nxt = 29'h1000_0000 - 29'(acsq2_r);
  assign lhs_nxt  = 61'(eisq3_r) * 61'(sin2_3_r);

  assign rhs  = 61'({etsq4_r, 28'd0});
  assign diff = rhs - lhs4_r;

  always_comb begin
    q_item.tir = (lhs4_r >= rhs);
    q_item.num = {diff[59:0], 4'd0};
    q_item.den = etsq4_r;
    q_item.ac  = ac4_r;
    q_item.ei  = ei4_r;
    q_item.et  = et4_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (fe) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fe) begin
      ac1_r    <= c_abs[14:0];
      ei1_r    <= exiting ? eta_t : eta_i;
      et1_r    <= exiting ? eta_i : eta_t;
      acsq2_r  <= acsq_nxt;
      eisq2_r  <= eisq_nxt;
      etsq2_r  <= etsq_nxt;
      ac2_r    <= ac1_r;
      ei2_r    <= ei1_r;
      et2_r    <= et1_r;
      sin2_3_r <= sin2_nxt;
      eisq3_r  <= eisq2_r;
      etsq3_r  <= etsq2_r;
      ac3_r    <= ac2_r;
      ei3_r    <= ei2_r;
      et3_r    <= et2_r;
      lhs4_r   <= lhs_nxt;
      etsq4_r  <= etsq3_r;
      ac4_r    <= ac3_r;
      ei4_r    <= ei3_r;
      et4_r    <= et3_r;
    end
  end
endmodule

FILE: hdl/fdr_fifo.sv
// Short word queue between the front end and the back end.
`timescale 1ns / 1ps
module fdr_fifo #(
  parameter int unsigned DEPTH = 4,
  parameter int unsigned W     = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] cnt_r;

  assign full  = (cnt_r == CW'(DEPTH));
  assign empty = (cnt_r == '0);
  assign rdata = mem_r[rd_ptr_r];

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (pop)  rd_ptr_r <= ptr_inc(rd_ptr_r);
      if (push && !pop)      cnt_r <= cnt_r + CW'(1);
      else if (pop && !push) cnt_r <= cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wdata;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
    else $error("queue pop while empty");
  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
      (push && !pop) |=> (cnt_r == $past(cnt_r) + CW'(1)))
    else $error("queue count did not advance on push");
endmodule

FILE: hdl/fdr_div.sv
// Pipelined restoring divider, one quotient bit per stage, with side payload.
`timescale 1ns / 1ps
module fdr_div #(
  parameter int unsigned NW = 64,
  parameter int unsigned DW = 32,
  parameter int unsigned QW = 33,
  parameter int unsigned PW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  logic [NW-1:0] in_num,
  input  logic [DW-1:0] in_den,
  input  logic [PW-1:0] in_pay,
  output logic          out_valid,
  output logic [QW-1:0] out_quo,
  output logic [PW-1:0] out_pay
);
  logic          vld_r [QW];
  logic [DW-1:0] rem_r [QW];
  logic [DW-1:0] den_r [QW];
  logic [QW-1:0] low_r [QW];
  logic [QW-1:0] quo_r [QW];
  logic [PW-1:0] pay_r [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic          v_i;
    logic [DW-1:0] rem_i, den_i;
    logic [QW-1:0] low_i, quo_i;
    logic [PW-1:0] pay_i;
    logic [DW:0]   t, t_sub;
    logic          ge;

    if (k == 0) begin : g_first
      // quotient fits QW bits, so the top of the dividend is below the divisor
      assign v_i   = in_valid;
      assign rem_i = DW'(in_num >> QW);
      assign low_i = in_num[QW-1:0];
      assign quo_i = '0;
      assign den_i = in_den;
      assign pay_i = in_pay;
    end else begin : g_next
      assign v_i   = vld_r[k-1];
      assign rem_i = rem_r[k-1];
      assign low_i = low_r[k-1];
      assign quo_i = quo_r[k-1];
      assign den_i = den_r[k-1];
      assign pay_i = pay_r[k-1];
    end

    assign t     = {rem_i, low_i[QW-1]};
    assign ge    = (t >= {1'b0, den_i});
    assign t_sub = t - {1'b0, den_i};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge ? t_sub[DW-1:0] : t[DW-1:0];
        low_r[k] <= low_i << 1;
        quo_r[k] <= {quo_i[QW-2:0], ge};
        den_r[k] <= den_i;
        pay_r[k] <= pay_i;
      end
    end
  end

  assign out_valid = vld_r[QW-1];
  assign out_quo   = quo_r[QW-1];
  assign out_pay   = pay_r[QW-1];
endmodule

FILE: hdl/fdr_back.sv
// Back end: cos^2 T divide, square root, Fresnel ratios, mean of squares, output register.
`timescale 1ns / 1ps
module fdr_back import fdr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  fdr_item_t   q_item,
  input  logic        q_empty,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [16:0] out_reflectance,
  output logic        out_total_internal
);
  localparam int unsigned SQ_N = 17;
  localparam int unsigned PAY_W = 1 + 15 + 16 + 16;

  logic adv;
  logic out_valid_r, out_tir_r;
  logic [16:0] out_refl_r;

  assign adv   = !out_valid_r || !out_stall;
  assign q_pop = adv && !q_empty;

  // cos^2 T
  logic             d1_v;
  logic [32:0]      cos2t;
  logic [PAY_W-1:0] d1_pay;

  fdr_div #(.NW(64), .DW(32), .QW(33), .PW(PAY_W)) u_div_cos (
    .clk(clk), .rst_n(rst_n), .en(adv),
    .in_valid(q_pop), .in_num(q_item.num), .in_den(q_item.den),
    .in_pay({q_item.tir, q_item.ac, q_item.ei, q_item.et}),
    .out_valid(d1_v), .out_quo(cos2t), .out_pay(d1_pay)
  );

  // floor square root, two radicand bits per stage
  logic             sq_v_r    [SQ_N];
  logic [33:0]      sq_x_r    [SQ_N];
  logic [19:0]      sq_rem_r  [SQ_N];
  logic [16:0]      sq_root_r [SQ_N];
  logic [PAY_W-1:0] sq_pay_r  [SQ_N];

  for (genvar j = 0; j < SQ_N; j++) begin : g_sqrt
    logic             v_i;
    logic [33:0]      x_i;
    logic [19:0]      rem_i;
    logic [16:0]      root_i;
    logic [PAY_W-1:0] pay_i;
    logic [21:0]      t, trial;
    logic             ge;

    if (j == 0) begin : g_first
      assign v_i    = d1_v;
      assign x_i    = {1'b0, cos2t};
      assign rem_i  = '0;
      assign root_i = '0;
      assign pay_i  = d1_pay;
    end else begin : g_next
      assign v_i    = sq_v_r[j-1];
      assign x_i    = sq_x_r[j-1];
      assign rem_i  = sq_rem_r[j-1];
      assign root_i = sq_root_r[j-1];
      assign pay_i  = sq_pay_r[j-1];
    end

    assign t     = {rem_i, x_i[33:32]};
    assign trial = {3'b000, root_i, 2'b01};
    assign ge    = (t >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_v_r[j] <= 1'b0;
      end else if (adv) begin
        sq_v_r[j] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sq_x_r[j]    <= x_i << 2;
        sq_rem_r[j]  <= ge ? 20'(t - trial) : t[19:0];
        sq_root_r[j] <= {root_i[15:0], ge};
        sq_pay_r[j]  <= pay_i;
      end
    end
  end

  // products of indices and cosines, Q4.28
  logic        sq_tir;
  logic [14:0] sq_ac;
  logic [15:0] sq_ei, sq_et;
  logic [16:0] ct, ci;

  assign {sq_tir, sq_ac, sq_ei, sq_et} = sq_pay_r[SQ_N-1];
  assign ct = sq_root_r[SQ_N-1];
  assign ci = {sq_ac, 2'b00};

  logic        p_v_r, p_tir_r;
  logic [32:0] p_a1_r, p_b1_r, p_a2_r, p_b2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_v_r <= 1'b0;
    end else if (adv) begin
      p_v_r <= sq_v_r[SQ_N-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_tir_r <= sq_tir;
      p_a1_r  <= 33'(sq_et) * 33'(ci);
      p_b1_r  <= 33'(sq_ei) * 33'(ct);
      p_a2_r  <= 33'(sq_ei) * 33'(ci);
      p_b2_r  <= 33'(sq_et) * 33'(ct);
    end
  end

  // sums and differences for the two ratios
  logic        sd_v_r, sd_tir_r;
  logic [33:0] sd_s1_r, sd_s2_r;
  logic [32:0] sd_d1_r, sd_d2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sd_v_r <= 1'b0;
    end else if (adv) begin
      sd_v_r <= p_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sd_tir_r <= p_tir_r;
      sd_s1_r  <= 34'(p_a1_r) + 34'(p_b1_r);
      sd_s2_r  <= 34'(p_a2_r) + 34'(p_b2_r);
      sd_d1_r  <= (p_a1_r > p_b1_r) ? p_a1_r - p_b1_r : p_b1_r - p_a1_r;
      sd_d2_r  <= (p_a2_r > p_b2_r) ? p_a2_r - p_b2_r : p_b2_r - p_a2_r;
    end
  end

  // ratios, Q0.24; a ratio of exactly one (one product zero) needs bit 24
  logic        r1_v, r2_v;
  logic [24:0] q1, q2;
  logic [1:0]  r1_pay;
  logic        r2_pay;

  fdr_div #(.NW(57), .DW(34), .QW(25), .PW(2)) u_div_par (
    .clk(clk), .rst_n(rst_n), .en(adv),
    .in_valid(sd_v_r), .in_num({sd_d1_r, 24'd0}), .in_den(sd_s1_r),
    .in_pay({sd_tir_r, sd_s1_r == '0}),
    .out_valid(r1_v), .out_quo(q1), .out_pay(r1_pay)
  );

  fdr_div #(.NW(57), .DW(34), .QW(25), .PW(1)) u_div_perp (
    .clk(clk), .rst_n(rst_n), .en(adv),
    .in_valid(sd_v_r), .in_num({sd_d2_r, 24'd0}), .in_den(sd_s2_r),
    .in_pay(sd_s2_r == '0),
    .out_valid(r2_v), .out_quo(q2), .out_pay(r2_pay)
  );

  // squares
  logic        qs_v_r, qs_tir_r, qs_bad_r;
  logic [48:0] qs_1_r, qs_2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qs_v_r <= 1'b0;
    end else if (adv) begin
      qs_v_r <= r1_v && r2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      qs_tir_r <= r1_pay[1];
      qs_bad_r <= r1_pay[0] || r2_pay;
      qs_1_r   <= 49'(q1) * 49'(q1);
      qs_2_r   <= 49'(q2) * 49'(q2);
    end
  end

  // half the sum, rounded half up, saturated; one on TIR or a zero denominator
  logic [49:0] sum;
  logic [16:0] mean, refl_nxt;

  assign sum  = 50'(qs_1_r) + 50'(qs_2_r) + 50'h1_0000_0000;
  assign mean = sum[49:33];

  always_comb begin
    if (qs_tir_r || qs_bad_r) begin
      refl_nxt = ONE_Q16;
    end else if (mean > ONE_Q16) begin
      refl_nxt = ONE_Q16;
    end else begin
      refl_nxt = mean;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= qs_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_refl_r <= refl_nxt;
      out_tir_r  <= qs_tir_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_reflectance    = out_refl_r;
  assign out_total_internal = out_tir_r;
endmodule

FILE: hdl/fresnel_dielectric_reflectance.sv
// Top level of the Fresnel dielectric reflectance block.
//
//   channel  direction  handshake          payload
//   in       input      in_valid/in_stall  in_cos_incidence (s16, Q2.14)
//   out      output     out_valid/out_stall out_reflectance (u17, Q1.16), out_total_internal
//   cfg      input      cfg_we             cfg_index, cfg_wdata (eta registers, Q4.12)
//
// One word accepted per cycle while in_stall is low. A word passes 84 register stages:
// 4 front stages, 1 in the queue, 33 for the cos^2 T divide, 17 for the square root,
// 2 product stages, 25 for the ratio divides, then the squares and the output register.
// Reset (synchronous, rst_n low) empties every stage and the queue and sets both
// indices to 1.0. A stalled output freezes the whole back end; the front end
// keeps running until the queue fills, then raises in_stall.
`timescale 1ns / 1ps
module fresnel_dielectric_reflectance import fdr_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic signed [15:0]   in_cos_incidence,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [16:0]          out_reflectance,
  output logic                 out_total_internal,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_wdata
);
  // index registers; to be written only while the block is idle, which the block itself does not enforce
  logic [15:0] eta_i_r, eta_t_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eta_i_r <= 16'd4096;
      eta_t_r <= 16'd4096;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ETA_INCIDENT: eta_i_r <= cfg_wdata;
        CFG_ETA_TRANSMIT: eta_t_r <= cfg_wdata;
        default: ;  // unmapped index: ignored
      endcase
    end
  end

  logic      q_push, q_pop, q_full, q_empty;
  fdr_item_t q_wr, q_rd;

  // front end: clamp, swap, TIR test
  fdr_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_cos_incidence(in_cos_incidence),
    .eta_i(eta_i_r), .eta_t(eta_t_r),
    .q_full(q_full), .q_push(q_push), .q_item(q_wr)
  );

  // decoupling queue
  fdr_fifo #(.DEPTH(QUEUE_DEPTH), .W($bits(fdr_item_t))) u_queue (
    .clk(clk), .rst_n(rst_n),
    .push(q_push), .wdata(q_wr), .full(q_full),
    .pop(q_pop), .rdata(q_rd), .empty(q_empty)
  );

  // back end: divides, root, ratios, output register
  fdr_back u_back (
    .clk(clk), .rst_n(rst_n),
    .q_item(q_rd), .q_empty(q_empty), .q_pop(q_pop),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_reflectance(out_reflectance), .out_total_internal(out_total_internal)
  );
endmodule

FILE: sim/tb.sv
// Self-checking testbench for the Fresnel dielectric reflectance block.
`timescale 1ns / 1ps
module tb;
  import fdr_pkg::*;

  typedef struct {
    logic [16:0] refl;
    logic        tir;
  } refl_result_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic signed [15:0]   in_cos_incidence;
  logic                 out_valid;
  logic                 out_stall;
  logic [16:0]          out_reflectance;
  logic                 out_total_internal;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [15:0]          cfg_wdata;

  fresnel_dielectric_reflectance u_dut (.*);

  // predictor copy of the index registers
  logic [15:0] eta_i_q;
  logic [15:0] eta_t_q;

  logic signed [15:0] cos_words[$];     // words waiting for the driver
  refl_result_t       refl_expected[$]; // predicted reflectance, oldest first
  int unsigned        send_idle_pct;
  int unsigned        recv_stall_pct;
  int unsigned        n_fail;
  bit                 hold_go;
  bit                 hold_active;
  int unsigned        hold_cnt;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("status: fail");
    $finish;
  end

  function automatic logic [63:0] isqrt64(logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Fresnel mean of squared ratios, same fixed-point steps as the block
  function automatic refl_result_t fresnel_refl(logic signed [15:0] cos_in);
    refl_result_t res;
    logic signed [31:0] c;
    logic [63:0] ei, et, tmp, ac, sin2, lhs, rhs, cos2t, ct, ci;
    logic [63:0] a1, b1, a2, b2, q1, q2, sum;
    c = 32'(cos_in);
    ei = 64'(eta_i_q);
    et = 64'(eta_t_q);
    if (c > COS_POS_ONE) c = 32'(COS_POS_ONE);
    if (c < COS_NEG_ONE) c = 32'(COS_NEG_ONE);
    // non-positive cosine: ray leaves the medium, indices swap
    if (c <= 0) begin
      tmp = ei; ei = et; et = tmp;
      c = -c;
    end
    ac = 64'(c);
    sin2 = (64'd1 << 28) - ac * ac;
    lhs = ei * ei * sin2;
    rhs = (et * et) << 28;
    res.tir = 1'b0;
    res.refl = ONE_Q16;
    if (lhs >= rhs) begin
      res.tir = 1'b1;
      return res;
    end
    cos2t = ((rhs - lhs) << 4) / (et * et);
    ct = isqrt64(cos2t);
    ci = ac << 2;
    a1 = et * ci; b1 = ei * ct;
    a2 = ei * ci; b2 = et * ct;
    // zero denominator: saturate, not flagged as TIR
    if (a1 + b1 == 0 || a2 + b2 == 0) return res;
    q1 = (((a1 > b1) ? a1 - b1 : b1 - a1) << 24) / (a1 + b1);
    q2 = (((a2 > b2) ? a2 - b2 : b2 - a2) << 24) / (a2 + b2);
    sum = (q1 * q1 + q2 * q2 + (64'd1 << 32)) >> 33;
    if (sum > ONE_Q16) sum = ONE_Q16;
    res.refl = sum[16:0];
    return res;
  endfunction

  // driver: offers the head of the word queue, holds it while stalled
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        refl_expected = {refl_expected, fresnel_refl(in_cos_incidence)};
        void'(cos_words.pop_front());
      end
      if (!in_valid || !in_stall) begin
        if (cos_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_cos_incidence <= cos_words[0];
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, counted here so the block backs up
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_active <= 1'b0;
      hold_cnt <= 0;
    end else if (hold_go && hold_cnt < 400) begin
      hold_active <= 1'b1;
      hold_cnt <= hold_cnt + 1;
    end else begin
      hold_active <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= hold_active || ($urandom_range(99) < recv_stall_pct);
  end

  // monitor: compare each accepted result with the oldest prediction
  always @(posedge clk) begin
    refl_result_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (refl_expected.size() == 0) begin
        $display("%0t unexpected word: refl=%0d tir=%0d", $time,
                 out_reflectance, out_total_internal);
        n_fail++;
      end else begin
        exp_r = refl_expected.pop_front();
        if (out_reflectance !== exp_r.refl) begin
          $display("%0t reflectance: expected %0d actual %0d", $time,
                   exp_r.refl, out_reflectance);
          n_fail++;
        end
        if (out_total_internal !== exp_r.tir) begin
          $display("%0t total_internal: expected %0d actual %0d", $time,
                   exp_r.tir, out_total_internal);
          n_fail++;
        end
      end
    end
  end

  task automatic add_word(logic signed [15:0] w);
    cos_words = {cos_words, w};
  endtask

  task automatic write_eta(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_ETA_INCIDENT) eta_i_q = val;
    else if (idx == CFG_ETA_TRANSMIT) eta_t_q = val;
  endtask

  task automatic set_etas(logic [15:0] ei, logic [15:0] et);
    write_eta(CFG_ETA_INCIDENT, ei);
    write_eta(CFG_ETA_TRANSMIT, et);
  endtask

  // wait until every word went in and every result came out, then let
  // the pipeline settle
  task automatic drain();
    while (cos_words.size() > 0 || refl_expected.size() > 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic add_random(int unsigned n);
    repeat (n) begin
      if ($urandom_range(3) == 0) add_word(16'($urandom()));
      else add_word(16'($signed($urandom_range(32768)) - 16384));
    end
  endtask

  task automatic set_mode(int unsigned m);
    case (m % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
      default: begin send_idle_pct = 31; recv_stall_pct = 31; end
    endcase
  endtask

  initial begin
    logic signed [15:0] corner_cos[12];
    corner_cos = '{16'sh7fff, 16'sh8000, 16384, -16384,
                   16385, -16385, 0, 1, -1, 8192, -8192, 100};
    n_fail = 0;
    hold_go = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_cos_incidence = '0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_ETA_INCIDENT;
    cfg_wdata = '0;
    eta_i_q = 16'd4096;
    eta_t_q = 16'd4096;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: field extremes at reset indices (1.0 / 1.0)
    foreach (corner_cos[k]) add_word(corner_cos[k]);
    drain();
    // dense to thin: TIR at positive cosines, before any swap
    set_etas(16'd6144, 16'd4096);
    foreach (corner_cos[k]) add_word(corner_cos[k]);
    drain();
    // zero incident index after swap, grazing exit: zero denominator
    set_etas(16'd1000, 16'd0);
    add_word(0);
    add_word(-16384);
    add_word(8000);
    drain();
    set_etas(16'd0, 16'd0);
    add_word(0);
    add_word(16384);
    drain();

    // random phases over several index settings
    for (int p = 0; p < 12; p++) begin
      case (p)
        0: set_etas(16'd1, 16'd65535);
        1: set_etas(16'd65535, 16'd1);
        2: set_etas(16'd65535, 16'd65535);
        3: set_etas(16'd4096, 16'd6144);
        default: set_etas(16'($urandom_range(65535, 1)), 16'($urandom_range(65535, 1)));
      endcase
      set_mode(p);
      if (p == 4) begin
        // receiver holds off while the sender keeps offering
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_go = 1'b1;
      end
      add_random(150);
      drain();
    end

    if (n_fail == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
